// File: rtl/core/frs_pkg.sv
package frs_pkg;

    // Default for the largest supported half width
    localparam int MAX_HALF_WIDTH_DEF = 32;

    // Field widths
    localparam int FIELD_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int HW_W      = 6;
    localparam int OW_W      = 6;
    localparam int FB_W      = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    // Register reset values
    localparam logic [HW_W-1:0] HALF_WIDTH_RST    = 6'd16;
    localparam logic [OW_W-1:0] OUTPUT_WIDTH_RST  = 6'd16;
    localparam logic [FB_W-1:0] FRACTION_BITS_RST = 7'd8;

    // Largest signed result width
    localparam logic [OW_W-1:0] OUT_WIDTH_MAX = 6'd32;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_ERR = 2'd2
    } t_status;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_WIDTH    = 2'd0,
        REG_OUTPUT_WIDTH  = 2'd1,
        REG_FRACTION_BITS = 2'd2
    } t_reg_idx;

    // Configuration seen by the datapath stages
    typedef struct packed {
        logic [HW_W-1:0] half_width;
        logic [OW_W-1:0] output_width;
        logic [FB_W-1:0] fraction_bits;
    } t_cfg;

endpackage

// File: rtl/core/fixed_point_round_saturate_core.sv
// Throughput: one transaction per cycle unless m_axis stalls; three register
// stages (input, magnitude, result) each hand on as soon as the next stage
// is free. Reset (synchronous, active low) empties all stages and loads the
// registers with half width 16, output width 16 and 8 fraction bits.
module fixed_point_round_saturate_core #(
    parameter int MAX_HALF_WIDTH = frs_pkg::MAX_HALF_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [frs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [frs_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] high_half, [63:32] low_half
    input  logic [63:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] rounded_value, [33:32] status, [39:34] zero
    output logic [39:0]                   m_axis_tdata
);

    localparam int VW = 2 * MAX_HALF_WIDTH;

    frs_pkg::t_cfg                       r_cfg;
    logic                                r_in_valid;
    logic [frs_pkg::FIELD_W-1:0]         r_high;
    logic [frs_pkg::FIELD_W-1:0]         r_low;

    logic                                mag_ready;
    logic                                mag_valid;
    logic                                mag_neg;
    logic [VW-1:0]                       mag;
    logic                                rnd_ready;
    logic signed [frs_pkg::FIELD_W-1:0]  out_value;
    frs_pkg::t_status                    out_status;

    // Configuration register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width    <= frs_pkg::HALF_WIDTH_RST;
            r_cfg.output_width  <= frs_pkg::OUTPUT_WIDTH_RST;
            r_cfg.fraction_bits <= frs_pkg::FRACTION_BITS_RST;
        end else if (i_cfg_we) begin
            case (frs_pkg::t_reg_idx'(i_cfg_index))
                frs_pkg::REG_HALF_WIDTH: begin
                    r_cfg.half_width <= i_cfg_wdata[frs_pkg::HW_W-1:0];
                end
                frs_pkg::REG_OUTPUT_WIDTH: begin
                    r_cfg.output_width <= i_cfg_wdata[frs_pkg::OW_W-1:0];
                end
                frs_pkg::REG_FRACTION_BITS: begin
                    r_cfg.fraction_bits <= i_cfg_wdata[frs_pkg::FB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !r_in_valid || mag_ready;

    // Input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_high <= s_axis_tdata[31:0];
            r_low  <= s_axis_tdata[63:32];
        end
    end

    frs_mag #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .VW             (VW)
    ) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_in_valid),
        .i_high  (r_high),
        .i_low   (r_low),
        .o_ready (mag_ready),
        .o_valid (mag_valid),
        .o_neg   (mag_neg),
        .o_mag   (mag),
        .i_ready (rnd_ready)
    );

    frs_round #(
        .VW (VW)
    ) u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (mag_valid),
        .i_neg    (mag_neg),
        .i_mag    (mag),
        .o_ready  (rnd_ready),
        .o_valid  (m_axis_tvalid),
        .o_value  (out_value),
        .o_status (out_status),
        .i_ready  (m_axis_tready)
    );

    // Pack the result transaction
    assign m_axis_tdata = {6'd0, out_status, out_value};

    // An error result is always zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_status == frs_pkg::ST_ERR) |-> (out_value == '0))
        else $error("error status with nonzero result");

    // Saturation is symmetric, so the most negative code never appears
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_value != 32'sh8000_0000))
        else $error("result reached the most negative code");

    // Input stalls only when the whole pipeline is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && mag_valid && r_in_valid))
        else $error("input stalled with a free stage");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!m_axis_tvalid && !mag_valid && !r_in_valid))
        else $error("stage valid after reset");

endmodule

// File: rtl/core/frs_mag.sv
module frs_mag #(
    parameter int MAX_HALF_WIDTH = frs_pkg::MAX_HALF_WIDTH_DEF,
    parameter int VW             = 2 * MAX_HALF_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  frs_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic [frs_pkg::FIELD_W-1:0] i_high,
    input  logic [frs_pkg::FIELD_W-1:0] i_low,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic                        o_neg,
    output logic [VW-1:0]               o_mag,
    input  logic                        i_ready
);

    localparam int SW = $clog2(VW);

    logic [frs_pkg::HW_W-1:0] w;
    logic [MAX_HALF_WIDTH-1:0] hmask;
    logic [VW-1:0]             full;
    logic [VW-1:0]             v;
    logic [frs_pkg::HW_W:0]    top_bit;
    logic                      neg;
    logic [VW-1:0]             mag;

    logic                      r_valid;
    logic                      r_neg;
    logic [VW-1:0]             r_mag;

    // Clamp the half width into its supported range
    always_comb begin
        if (i_cfg.half_width == '0) begin
            w = frs_pkg::HW_W'(1);
        end else if (i_cfg.half_width > frs_pkg::HW_W'(MAX_HALF_WIDTH)) begin
            w = frs_pkg::HW_W'(MAX_HALF_WIDTH);
        end else begin
            w = i_cfg.half_width;
        end
    end

    // Build masks for one half and for the joined value
    always_comb begin
        for (int i = 0; i < MAX_HALF_WIDTH; i++) begin
            hmask[i] = (i < int'(w));
        end
        for (int i = 0; i < VW; i++) begin
            full[i] = (i < 2 * int'(w));
        end
    end

    // Join the halves, take the sign and form the magnitude
    always_comb begin
        v = ((VW'(i_high[MAX_HALF_WIDTH-1:0] & hmask)) << w)
            | VW'(i_low[MAX_HALF_WIDTH-1:0] & hmask);
        top_bit = {w, 1'b0} - (frs_pkg::HW_W + 1)'(1);
        neg     = v[top_bit[SW-1:0]];
        mag     = neg ? ((VW'(0) - v) & full) : v;
    end

    assign o_ready = !r_valid || i_ready;

    // Advance the stage whenever the next one can take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the magnitude payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= neg;
            r_mag <= mag;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;

endmodule

// File: rtl/core/frs_round.sv
module frs_round #(
    parameter int VW = 2 * frs_pkg::MAX_HALF_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  frs_pkg::t_cfg                      i_cfg,
    input  logic                               i_valid,
    input  logic                               i_neg,
    input  logic [VW-1:0]                      i_mag,
    output logic                               o_ready,
    output logic                               o_valid,
    output logic signed [frs_pkg::FIELD_W-1:0] o_value,
    output frs_pkg::t_status                   o_status,
    input  logic                               i_ready
);

    localparam int TW = (VW + 1 > 32) ? VW + 1 : 32;

    logic [VW:0]                   t;
    logic [TW-1:0]                 t_ext;
    logic                          err;
    logic [31:0]                   sum;
    logic [31:0]                   r;
    logic [frs_pkg::OW_W-1:0]      ow;
    logic [31:0]                   limit;
    logic [31:0]                   r_sel;
    frs_pkg::t_status              status;
    logic [31:0]                   value;

    logic                          r_valid;
    logic [31:0]                   r_value;
    frs_pkg::t_status              r_status;

    // Shift to one extra fraction bit; with no fraction bits, double instead
    always_comb begin
        if (i_cfg.fraction_bits == '0) begin
            t = {i_mag, 1'b0};
        end else begin
            t = {1'b0, i_mag} >> (i_cfg.fraction_bits - frs_pkg::FB_W'(1));
        end
        t_ext = TW'(t);
        err   = |t_ext[TW-1:31];
        sum   = {1'b0, t_ext[30:0]} + 32'd1;
        r     = {1'b0, sum[31:1]};
    end

    // Clamp the output width and find the symmetric limit
    always_comb begin
        if (i_cfg.output_width == '0) begin
            ow = frs_pkg::OW_W'(1);
        end else if (i_cfg.output_width > frs_pkg::OUT_WIDTH_MAX) begin
            ow = frs_pkg::OUT_WIDTH_MAX;
        end else begin
            ow = i_cfg.output_width;
        end
        limit = (32'd1 << (ow - frs_pkg::OW_W'(1))) - 32'd1;
    end

    // Pick error, saturation or the rounded value, then restore the sign
    always_comb begin
        if (err) begin
            r_sel  = 32'd0;
            status = frs_pkg::ST_ERR;
        end else if (r > limit) begin
            r_sel  = limit;
            status = frs_pkg::ST_SAT;
        end else begin
            r_sel  = r;
            status = frs_pkg::ST_OK;
        end
        value = i_neg ? (32'd0 - r_sel) : r_sel;
    end

    assign o_ready = !r_valid || i_ready;

    // Advance the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_value  <= value;
            r_status <= status;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// File: tb/fixed_point_round_saturate_checker.sv
module fixed_point_round_saturate_checker
    import frs_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    // [31:0] high_half, [63:32] low_half
    input  logic [63:0]          i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    // [31:0] rounded_value, [33:32] status, [39:34] zero
    input  logic [39:0]          i_out_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_ok_count,
    output int                   o_sat_count,
    output int                   o_err_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        t_status            status;
    } t_rounded;

    t_cfg     shadow_cfg;
    t_rounded pending_rounds[$];

    // Round half up on the magnitude, restore the sign, saturate or flag error
    function automatic t_rounded predict_rounding(logic [31:0] hi, logic [31:0] lo, t_cfg cfg);
        int unsigned w, ow, fb, sh;
        logic [63:0] hmask, full, v, mag, t, r, limit;
        logic        neg;
        t_rounded    res;
        w  = int'(cfg.half_width);
        ow = int'(cfg.output_width);
        fb = int'(cfg.fraction_bits);
        if (w < 1) w = 1;
        if (w > MAX_HALF_WIDTH) w = MAX_HALF_WIDTH;
        if (w > 32) w = 32;
        if (ow < 1) ow = 1;
        if (ow > 32) ow = 32;
        hmask = (64'd1 << w) - 64'd1;
        full  = (2 * w >= 64) ? '1 : ((64'd1 << (2 * w)) - 64'd1);
        v     = ((({32'd0, hi} & hmask) << w) | ({32'd0, lo} & hmask)) & full;
        neg   = v[2*w-1];
        mag   = neg ? ((~v + 64'd1) & full) : v;
        limit = (64'd1 << (ow - 1)) - 64'd1;
        res.status = ST_OK;
        if (fb == 0) begin
            // no rounding, magnitude passes straight through
            if (mag >= (64'd1 << 30)) begin
                r = '0;
                res.status = ST_ERR;
            end else begin
                r = mag;
            end
        end else begin
            sh = fb - 1;
            t  = (sh >= 64) ? 64'd0 : (mag >> sh);
            if (t >= (64'd1 << 31)) begin
                r = '0;
                res.status = ST_ERR;
            end else begin
                r = (t + 64'd1) >> 1;
            end
        end
        if (res.status == ST_OK && r > limit) begin
            r = limit;
            res.status = ST_SAT;
        end
        res.value = neg ? (~r[31:0] + 32'd1) : r[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rounded   want;
        logic [1:0] got_status;
        if (!i_rst_n) begin
            shadow_cfg   = '{HALF_WIDTH_RST, OUTPUT_WIDTH_RST, FRACTION_BITS_RST};
            pending_rounds.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_ok_count   = 0;
            o_sat_count  = 0;
            o_err_count  = 0;
        end else begin
            // Track register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HALF_WIDTH:    shadow_cfg.half_width    = i_cfg_wdata[HW_W-1:0];
                    REG_OUTPUT_WIDTH:  shadow_cfg.output_width  = i_cfg_wdata[OW_W-1:0];
                    REG_FRACTION_BITS: shadow_cfg.fraction_bits = i_cfg_wdata[FB_W-1:0];
                    default: ;
                endcase
            end

            // Predict each input transaction
            if (i_in_valid && i_in_ready) begin
                pending_rounds.push_back(
                    predict_rounding(i_in_data[31:0], i_in_data[63:32], shadow_cfg));
            end

            // Compare each output transaction with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pending_rounds.size() == 0) begin
                    $error("unexpected result: rounded_value %0d status %0d",
                           $signed(i_out_data[31:0]), i_out_data[33:32]);
                    o_fail_count++;
                end else begin
                    want       = pending_rounds.pop_front();
                    got_status = i_out_data[33:32];
                    if (i_out_data[31:0] !== want.value) begin
                        $error("rounded_value: expected %0d, actual %0d",
                               $signed(want.value), $signed(i_out_data[31:0]));
                        o_fail_count++;
                    end
                    if (got_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got_status);
                        o_fail_count++;
                    end
                    if (i_out_data[39:34] !== '0) begin
                        $error("padding: expected 0, actual %0h", i_out_data[39:34]);
                        o_fail_count++;
                    end
                    case (want.status)
                        ST_SAT:  o_sat_count++;
                        ST_ERR:  o_err_count++;
                        default: o_ok_count++;
                    endcase
                end
            end
            o_pending = pending_rounds.size();
        end
    end

endmodule

// File: tb/tb_fixed_point_round_saturate_core.sv
module tb_fixed_point_round_saturate_core;
    import frs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 112;
    localparam int STALL_CYCLES  = 80;
    localparam int DRAIN_CYCLES  = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // [31:0] high_half, [63:32] low_half
    logic [63:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [31:0] rounded_value, [33:32] status, [39:34] zero
    logic [39:0]          m_axis_tdata;

    int fail_count, pending, ok_count, sat_count, err_count;

    // Stimulus-side view of the settings, used only to shape values
    int unsigned cur_hw, cur_ow, cur_fb;
    int          settings_used;
    bit          steady;
    int          stall_requests, stalls_served = 0, stall_left = 0;

    always #5 i_clk = ~i_clk;

    fixed_point_round_saturate_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fixed_point_round_saturate_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ok_count   (ok_count),
        .o_sat_count  (sat_count),
        .o_err_count  (err_count)
    );

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (stalls_served < stall_requests) begin
            stall_left = STALL_CYCLES;
            stalls_served++;
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // Offer one transaction, idling at random first; call and return at negedge
    task automatic send_item(logic [31:0] hi, logic [31:0] lo);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
    endtask

    // Drain the block, then load all three registers
    task automatic set_config(int unsigned hw, int unsigned ow, int unsigned fb);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        write_reg(REG_HALF_WIDTH, hw[CFG_DAT_W-1:0]);
        write_reg(REG_OUTPUT_WIDTH, ow[CFG_DAT_W-1:0]);
        write_reg(REG_FRACTION_BITS, fb[CFG_DAT_W-1:0]);
        i_cfg_we <= 1'b0;
        cur_hw = hw & 6'h3F;
        cur_ow = ow & 6'h3F;
        cur_fb = fb & 7'h7F;
        settings_used++;
    endtask

    // Build a value that lands near zero, a rounding tie, the limit or the error edge
    task automatic send_shaped();
        int unsigned w, owc, fb, k, kind;
        logic [63:0] full, mag, v, thr;
        logic [31:0] hmask32, hi, lo;
        logic        neg;
        w   = (cur_hw < 1) ? 1 : (cur_hw > 32) ? 32 : cur_hw;
        owc = (cur_ow < 1) ? 1 : (cur_ow > 32) ? 32 : cur_ow;
        fb  = cur_fb;
        full    = (w == 32) ? '1 : ((64'd1 << (2 * w)) - 64'd1);
        hmask32 = (w == 32) ? '1 : ((32'd1 << w) - 32'd1);
        kind = $urandom_range(0, 99);
        neg  = 1'($urandom_range(0, 1));
        k    = $urandom_range(0, 2 * w - 1);
        mag  = {$urandom, $urandom} & ((64'd1 << k) - 64'd1);
        if (kind >= 60 && kind < 80 && fb >= 1 && fb < 2 * w) begin
            // exact half, nudged by one step at times
            mag = ((mag >> fb) << fb) | (64'd1 << (fb - 1));
            case ($urandom_range(0, 2))
                0: mag = mag - 64'd1;
                1: mag = mag + 64'd1;
                default: ;
            endcase
        end else if (kind >= 80 && kind < 90 && fb < 32) begin
            mag = (((64'd1 << (owc - 1)) + $urandom_range(0, 2) - 64'd2) << fb)
                  + ({32'd0, $urandom} & ((64'd1 << fb) - 64'd1));
        end else if (kind >= 90 && fb < 33) begin
            thr = 64'd1 << ((fb == 0) ? 30 : 30 + fb);
            mag = thr + $urandom_range(0, 3) - 64'd2;
        end
        v = (kind < 25) ? {$urandom, $urandom} : (neg ? (~mag + 64'd1) : mag);
        v = v & full;
        hi = 32'(v >> w);
        lo = v[31:0] & hmask32;
        // fill the ignored upper bits with noise
        hi = hi | ($urandom & ~hmask32);
        lo = lo | ($urandom & ~hmask32);
        send_item(hi, lo);
    endtask

    // Pick settings, mostly in the legal range
    task automatic random_config();
        int unsigned hw, ow, fb, w;
        hw = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 32) : $urandom_range(0, 63);
        ow = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 32) : $urandom_range(0, 63);
        w  = (hw < 1) ? 1 : (hw > 32) ? 32 : hw;
        fb = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2 * w + 1) : $urandom_range(0, 127);
        set_config(hw, ow, fb);
    endtask

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_HALF_WIDTH;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        steady         = 1'b0;
        stall_requests = 0;
        settings_used  = 1;
        cur_hw = int'(HALF_WIDTH_RST);
        cur_ow = int'(OUTPUT_WIDTH_RST);
        cur_fb = int'(FRACTION_BITS_RST);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: ties, negative zero, both saturation ends, ignored bits
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h0000_FFFF, 32'h0000_FFFF);
        send_item(32'h0000_0000, 32'h0000_0080);
        send_item(32'h0000_FFFF, 32'h0000_FF80);
        send_item(32'h0000_0000, 32'h0000_007F);
        send_item(32'h0000_7FFF, 32'h0000_FFFF);
        send_item(32'h0000_8000, 32'h0000_0000);
        send_item(32'hFFFF_0000, 32'hABCD_0123);

        // A write to an unknown index must leave the settings alone
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        write_reg(REG_UNUSED, 7'h7F);
        i_cfg_we <= 1'b0;
        send_item(32'h0000_0001, 32'h0000_0180);

        // Widest halves, one fraction bit: error edge
        set_config(32, 32, 1);
        send_item(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h0000_0000, 32'hFFFF_FFFF);
        send_item(32'h0000_0000, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h0000_0000);

        // Limit of zero: error wins over saturation
        set_config(32, 1, 1);
        send_item(32'h0000_0001, 32'h0000_0000);
        send_item(32'h0000_0000, 32'h0000_0003);

        // Zero half width, zero output width, no rounding
        set_config(0, 0, 0);
        send_item(32'h0000_0001, 32'h0000_0001);
        send_item(32'h0000_0000, 32'h0000_0001);

        // Oversized settings: everything shifts out
        set_config(63, 63, 127);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h8000_0000, 32'h0000_0000);

        // No rounding at full width: just under and at the error edge
        set_config(32, 32, 0);
        send_item(32'h0000_0000, 32'h3FFF_FFFF);
        send_item(32'h0000_0000, 32'h4000_0000);
        send_item(32'hFFFF_FFFF, 32'hC000_0001);

        // Random phases, extremes first
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(16, 16, 8);
                1: set_config(32, 32, 1);
                2: set_config(32, 32, 0);
                3: set_config(1, 1, 1);
                4: set_config(8, 32, 127);
                5: set_config(32, 16, 16);
                6: set_config(0, 0, 64);
                7: set_config(63, 63, 65);
                default: random_config();
            endcase
            steady = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == 20) stall_requests++;
                send_shaped();
            end
            steady = 1'b0;
        end

        // Drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d register settings and %0d results:",
                 settings_used, ok_count + sat_count + err_count);
        $display("  %0d in range, %0d saturated, %0d out of range", ok_count, sat_count,
                 err_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
